>>> rtl/core/caf_pkg.sv
// Shared types, constants and codes of the CAN identifier allow-list filter.
package caf_pkg;

    // Allow-list geometry
    localparam int LIST_DEPTH = 256;
    localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    // Field widths
    localparam int CMD_W  = 2;
    localparam int ID_W   = 32;
    localparam int FLEN_W = 8;
    localparam int SLEN_W = 6;

    // Longest frame record that goes to the client
    localparam logic [SLEN_W-1:0] MAX_SENT_LEN = SLEN_W'(32);

    // Stream widths, padded to whole bytes
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 24;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CHECK     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DENY_ALL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ALLOW_ALL = 2'd2;
    localparam logic [CMD_W-1:0] CMD_ADD_ID    = 2'd3;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    // One result transaction
    typedef struct packed {
        logic [CNT_W-1:0]  list_count;
        logic              add_dropped;
        logic [SLEN_W-1:0] sent_len;
        logic              forward;
    } result_t;

    // One input item
    typedef struct packed {
        logic [FLEN_W-1:0] frame_len;
        logic [ID_W-1:0]   can_id;
        logic [CMD_W-1:0]  command;
    } item_t;

endpackage

>>> rtl/core/caf_list_ram.sv
// Identifier store: one write port, one read port, registered read data.
module caf_list_ram
    import caf_pkg::*;
(
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [ID_W-1:0]   wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [ID_W-1:0]   rd_data
);

    logic [ID_W-1:0] mem [LIST_DEPTH];
    logic [ID_W-1:0] rd_data_reg;

    // Write one entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one entry into the registered read data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/caf_seq.sv
// Command sequencer: latches an item, walks the list memory, updates list state.
module caf_seq
    import caf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    notify_on,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    state_t            state_reg, state_next;
    item_t             item_reg;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              found_reg, found_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              enabled_reg, enabled_next;

    logic              accept;
    logic              finish;
    logic              list_full;
    logic              last_entry;
    logic              hit;
    logic              mem_wr_en;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [ID_W-1:0]   mem_rd_data;

    caf_list_ram u_list_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (item_reg.can_id),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign list_full  = (count_reg == CNT_W'(LIST_DEPTH));
    assign last_entry = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign hit        = (mem_rd_data == item_reg.can_id);
    assign accept     = item_valid && item_ready;
    assign finish     = (state_reg == ST_FINISH) && res_ready;

    // Next state, memory requests and result
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        found_next   = found_reg;
        count_next   = count_reg;
        enabled_next = enabled_reg;
        item_ready   = 1'b0;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = '0;
        mem_wr_en    = 1'b0;
        res_valid    = 1'b0;
        res          = '0;

        case (state_reg)
            ST_IDLE: begin
                item_ready = 1'b1;
                if (item_valid) begin
                    found_next = 1'b0;
                    idx_next   = '0;
                    mem_rd_en  = 1'b1;
                    if (item.command == CMD_CHECK && notify_on && enabled_reg
                            && count_reg != '0) begin
                        state_next = ST_SEARCH;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_SEARCH: begin
                // compare the entry read last cycle, fetch the next one
                if (hit) begin
                    found_next = 1'b1;
                    state_next = ST_FINISH;
                end else if (last_entry) begin
                    state_next = ST_FINISH;
                end else begin
                    idx_next    = idx_reg + ADDR_W'(1);
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_reg + ADDR_W'(1);
                end
            end

            ST_FINISH: begin
                res_valid = 1'b1;
                case (item_reg.command)
                    CMD_CHECK: begin
                        res.sent_len = (item_reg.frame_len > FLEN_W'(MAX_SENT_LEN))
                                     ? MAX_SENT_LEN
                                     : item_reg.frame_len[SLEN_W-1:0];
                        res.forward  = notify_on && (!enabled_reg || found_reg);
                    end
                    CMD_DENY_ALL: begin
                        enabled_next = 1'b1;
                    end
                    CMD_ALLOW_ALL: begin
                        enabled_next = 1'b0;
                        count_next   = '0;
                    end
                    CMD_ADD_ID: begin
                        if (enabled_reg) begin
                            if (list_full) begin
                                res.add_dropped = 1'b1;
                            end else begin
                                mem_wr_en  = res_ready;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                res.list_count = count_next;
                if (!res_ready) begin
                    // hold state until the output slot frees
                    count_next   = count_reg;
                    enabled_next = enabled_reg;
                end else begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            enabled_reg <= 1'b0;
            found_reg   <= 1'b0;
            idx_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            enabled_reg <= enabled_next;
            found_reg   <= found_next;
            idx_reg     <= idx_next;
        end
    end

    // Latch the accepted item
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item;
        end
    end

    // Assertions
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("list count above depth");

    a_search_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SEARCH |-> CNT_W'(idx_reg) < count_reg)
        else $error("search index beyond stored entries");

    a_allow_all_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (finish && item_reg.command == CMD_ALLOW_ALL) |=> (count_reg == '0 && !enabled_reg))
        else $error("allow all did not empty the list");

    a_full_add_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (finish && item_reg.command == CMD_ADD_ID && list_full)
        |=> count_reg == CNT_W'(LIST_DEPTH))
        else $error("add on full list changed the count");

    a_search_only_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SEARCH |-> (enabled_reg && item_reg.command == CMD_CHECK))
        else $error("search started without an enabled list");

endmodule

>>> rtl/core/can_id_allow_list_filter_unit.sv
// Top level of the CAN identifier allow-list filter: stream ports, config register, output slot.
//
// Each input transaction carries one command and yields one result transaction. Deny all,
// allow all, add id and frame checks that need no list lookup pass from ST_IDLE through
// ST_FINISH back to ST_IDLE. A frame check with notify_on set and the list enabled and
// non-empty walks the stored identifiers one per cycle through the single read port of the
// list memory and stops at the first match or after the last stored entry. The result sits
// in an output register, so the next transaction is taken while a finished result waits.
// List memory needs no clearing after reset: only entries below the fill count are compared.
module can_id_allow_list_filter_unit
    import caf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // configuration write
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,        // notify_on
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,         // command[1:0], can_id[33:2], frame_len[41:34]
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata          // forward[0], sent_len[6:1],
                                                 // add_dropped[7], list_count[16:8]
);

    logic    notify_on_reg;
    logic    m_valid_reg;
    result_t m_data_reg;
    item_t   item;
    logic    res_valid;
    logic    res_ready;
    result_t res;

    assign item = s_tdata[$bits(item_t)-1:0];

    caf_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .notify_on  (notify_on_reg),
        .item_valid (s_tvalid),
        .item_ready (s_tready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Config register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            notify_on_reg <= 1'b0;
        end else if (cfg_valid) begin
            notify_on_reg <= cfg_data;
        end
    end

    // Output slot: free when empty or being drained
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'(m_data_reg);

endmodule
